// ===== hw/rtl/segment_intersection_test_top_defines.svh =====
// assertion macros for the segment intersection test
`ifndef SEGMENT_INTERSECTION_TEST_TOP_DEFINES_SVH
`define SEGMENT_INTERSECTION_TEST_TOP_DEFINES_SVH

// condition implies consequence in the same cycle
`define SIT_ASSERT_NOW(label, cond, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (cons)) \
		else $error(msg);

// condition implies consequence in the next cycle
`define SIT_ASSERT_NEXT(label, cond, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/sit_pkg.sv =====
// shared types for the segment intersection test pipeline
package sit_pkg;

	// orientation of a point triple
	typedef enum logic [1:0] {
		TURN_COLL = 2'd0,
		TURN_CW   = 2'd1,
		TURN_CCW  = 2'd2
	} turn_t;

	// per-stage advance enables
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
	} pipe_en_t;

endpackage

// ===== hw/rtl/segment_intersection_test_top.sv =====
// segment intersection test: four-stage pipeline with output register
//
//  channel | valid        | stall        | payload
//  --------+--------------+--------------+------------------------------------
//  item    | item_valid   | item_stall   | first_/second_ start/end x/y
//  result  | result_valid | result_stall | segments_intersect
//
// an item passes through stages s1 to s4 from transfer in to result valid, one item per cycle while result_stall is low
// stages: differences and box compares, products, cross sign, hit decision
// the depth is set by the 2*COORD_BITS+2 bit multiply and the cross product subtract
// each stage advances when empty or when the stage after it advances, so bubbles close up
// item_stall rises only when all four stages hold items and result_stall is high
// arst_n clears the valid bits only; the data registers need no reset
module segment_intersection_test_top import sit_pkg::*; #(
	parameter int COORD_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         item_valid,
	output logic                         item_stall,
	input  logic signed [COORD_BITS-1:0] first_start_x,
	input  logic signed [COORD_BITS-1:0] first_start_y,
	input  logic signed [COORD_BITS-1:0] first_end_x,
	input  logic signed [COORD_BITS-1:0] first_end_y,
	input  logic signed [COORD_BITS-1:0] second_start_x,
	input  logic signed [COORD_BITS-1:0] second_start_y,
	input  logic signed [COORD_BITS-1:0] second_end_x,
	input  logic signed [COORD_BITS-1:0] second_end_y,
	output logic                         result_valid,
	input  logic                         result_stall,
	output logic                         segments_intersect
);

`include "segment_intersection_test_top_defines.svh"

	pipe_en_t pe;
	logic     v_s1, v_s2, v_s3, v_s4;
	logic     hit_s4;
	turn_t    t1_s3, t2_s3, t3_s3, t4_s3;
	logic     box1_s3, box2_s3, box3_s3, box4_s3;
	logic     cross_hit, hit;

	assign pe.s4 = !v_s4 || !result_stall;
	assign pe.s3 = !v_s3 || pe.s4;
	assign pe.s2 = !v_s2 || pe.s3;
	assign pe.s1 = !v_s1 || pe.s2;

	assign item_stall   = !pe.s1;
	assign result_valid = v_s4;
	assign segments_intersect = hit_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (pe.s1) v_s1 <= item_valid;
			if (pe.s2) v_s2 <= v_s1;
			if (pe.s3) v_s3 <= v_s2;
			if (pe.s4) v_s4 <= v_s3;
		end
	end

	sit_orient #(.COORD_BITS(COORD_BITS)) u_turn1 (
		.clk(clk), .pe(pe),
		.a_x(first_start_x), .a_y(first_start_y),
		.b_x(first_end_x), .b_y(first_end_y),
		.c_x(second_start_x), .c_y(second_start_y),
		.turn_s3(t1_s3)
	);

	sit_orient #(.COORD_BITS(COORD_BITS)) u_turn2 (
		.clk(clk), .pe(pe),
		.a_x(first_start_x), .a_y(first_start_y),
		.b_x(first_end_x), .b_y(first_end_y),
		.c_x(second_end_x), .c_y(second_end_y),
		.turn_s3(t2_s3)
	);

	sit_orient #(.COORD_BITS(COORD_BITS)) u_turn3 (
		.clk(clk), .pe(pe),
		.a_x(second_start_x), .a_y(second_start_y),
		.b_x(second_end_x), .b_y(second_end_y),
		.c_x(first_start_x), .c_y(first_start_y),
		.turn_s3(t3_s3)
	);

	sit_orient #(.COORD_BITS(COORD_BITS)) u_turn4 (
		.clk(clk), .pe(pe),
		.a_x(second_start_x), .a_y(second_start_y),
		.b_x(second_end_x), .b_y(second_end_y),
		.c_x(first_end_x), .c_y(first_end_y),
		.turn_s3(t4_s3)
	);

	sit_box #(.COORD_BITS(COORD_BITS)) u_box1 (
		.clk(clk), .pe(pe),
		.a_x(first_start_x), .a_y(first_start_y),
		.m_x(second_start_x), .m_y(second_start_y),
		.b_x(first_end_x), .b_y(first_end_y),
		.in_box_s3(box1_s3)
	);

	sit_box #(.COORD_BITS(COORD_BITS)) u_box2 (
		.clk(clk), .pe(pe),
		.a_x(first_start_x), .a_y(first_start_y),
		.m_x(second_end_x), .m_y(second_end_y),
		.b_x(first_end_x), .b_y(first_end_y),
		.in_box_s3(box2_s3)
	);

	sit_box #(.COORD_BITS(COORD_BITS)) u_box3 (
		.clk(clk), .pe(pe),
		.a_x(second_start_x), .a_y(second_start_y),
		.m_x(first_start_x), .m_y(first_start_y),
		.b_x(second_end_x), .b_y(second_end_y),
		.in_box_s3(box3_s3)
	);

	sit_box #(.COORD_BITS(COORD_BITS)) u_box4 (
		.clk(clk), .pe(pe),
		.a_x(second_start_x), .a_y(second_start_y),
		.m_x(first_end_x), .m_y(first_end_y),
		.b_x(second_end_x), .b_y(second_end_y),
		.in_box_s3(box4_s3)
	);

	// general case: each segment's endpoints on different sides of the other
	assign cross_hit = (t1_s3 != t2_s3) && (t3_s3 != t4_s3);

	// collinear special cases need the endpoint inside the other segment's box
	assign hit = cross_hit ||
		((t1_s3 == TURN_COLL) && box1_s3) ||
		((t2_s3 == TURN_COLL) && box2_s3) ||
		((t3_s3 == TURN_COLL) && box3_s3) ||
		((t4_s3 == TURN_COLL) && box4_s3);

	always_ff @(posedge clk) begin
		if (pe.s4) begin
			hit_s4 <= hit;
		end
	end

	`SIT_ASSERT_NEXT(a_s3_held, v_s3 && !pe.s3, v_s3, "stage three item lost during stall")
	`SIT_ASSERT_NOW(a_room_taken, !v_s1, !item_stall, "empty first stage refuses an item")
	`SIT_ASSERT_NEXT(a_cross_hit, v_s3 && pe.s4 && cross_hit, v_s4 && hit_s4, "crossing lost")

endmodule

// ===== hw/rtl/sit_orient.sv =====
// three-stage exact cross product and orientation of a point triple
module sit_orient import sit_pkg::*; #(
	parameter int COORD_BITS = 16
) (
	input  logic                         clk,
	input  pipe_en_t                     pe,
	input  logic signed [COORD_BITS-1:0] a_x,
	input  logic signed [COORD_BITS-1:0] a_y,
	input  logic signed [COORD_BITS-1:0] b_x,
	input  logic signed [COORD_BITS-1:0] b_y,
	input  logic signed [COORD_BITS-1:0] c_x,
	input  logic signed [COORD_BITS-1:0] c_y,
	output turn_t                        turn_s3
);

	localparam int DW = COORD_BITS + 1;
	localparam int PW = 2 * COORD_BITS + 2;
	localparam int XW = 2 * COORD_BITS + 3;

	logic signed [DW-1:0] dby_s1, dcx_s1, dbx_s1, dcy_s1;
	logic signed [PW-1:0] p1_s2, p2_s2;
	logic signed [XW-1:0] xprod;

	always_ff @(posedge clk) begin
		if (pe.s1) begin
			dby_s1 <= DW'(b_y) - DW'(a_y);
			dcx_s1 <= DW'(c_x) - DW'(b_x);
			dbx_s1 <= DW'(b_x) - DW'(a_x);
			dcy_s1 <= DW'(c_y) - DW'(b_y);
		end
	end

	always_ff @(posedge clk) begin
		if (pe.s2) begin
			p1_s2 <= PW'(dby_s1) * PW'(dcx_s1);
			p2_s2 <= PW'(dbx_s1) * PW'(dcy_s1);
		end
	end

	assign xprod = XW'(p1_s2) - XW'(p2_s2);

	always_ff @(posedge clk) begin
		if (pe.s3) begin
			if (xprod == '0) begin
				turn_s3 <= TURN_COLL;
			end else if (xprod[XW-1]) begin
				turn_s3 <= TURN_CCW;
			end else begin
				turn_s3 <= TURN_CW;
			end
		end
	end

endmodule

// ===== hw/rtl/sit_box.sv =====
// bounding box test of a point against a segment, delayed to stage three
module sit_box import sit_pkg::*; #(
	parameter int COORD_BITS = 16
) (
	input  logic                         clk,
	input  pipe_en_t                     pe,
	input  logic signed [COORD_BITS-1:0] a_x,
	input  logic signed [COORD_BITS-1:0] a_y,
	input  logic signed [COORD_BITS-1:0] m_x,
	input  logic signed [COORD_BITS-1:0] m_y,
	input  logic signed [COORD_BITS-1:0] b_x,
	input  logic signed [COORD_BITS-1:0] b_y,
	output logic                         in_box_s3
);

	logic in_x, in_y;
	logic in_box_s1, in_box_s2;

	// m within [min, max] of each axis without forming min and max
	assign in_x = ((m_x <= a_x) || (m_x <= b_x)) && ((m_x >= a_x) || (m_x >= b_x));
	assign in_y = ((m_y <= a_y) || (m_y <= b_y)) && ((m_y >= a_y) || (m_y >= b_y));

	always_ff @(posedge clk) begin
		if (pe.s1) begin
			in_box_s1 <= in_x && in_y;
		end
		if (pe.s2) begin
			in_box_s2 <= in_box_s1;
		end
		if (pe.s3) begin
			in_box_s3 <= in_box_s2;
		end
	end

endmodule

// ===== bench/testbench.sv =====
// self-checking testbench for the segment intersection test pipeline
module testbench import sit_pkg::*;;

	localparam int COORD_BITS = 16;
	localparam int RANDOM_PAIRS = 700;
	localparam int HOLD_CYCLES = 80;
	localparam int SETTLE_CYCLES = 12;

	typedef logic [COORD_BITS-1:0] coord_t;

	// drain_before: hold this pair back until every pending verdict has come out
	typedef struct packed {
		logic   drain_before;
		coord_t a_sx;
		coord_t a_sy;
		coord_t a_ex;
		coord_t a_ey;
		coord_t b_sx;
		coord_t b_sy;
		coord_t b_ex;
		coord_t b_ey;
	} seg_pair_t;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      item_valid = 1'b0;
	logic      item_stall;
	logic      result_valid;
	logic      result_stall = 1'b0;
	logic      segments_intersect;
	seg_pair_t cur_pair = '0;

	seg_pair_t pending_pairs[$];
	bit        verdicts_due[$];
	logic      in_xfer = 1'b0;
	int        pairs_sent = 0;
	int        verdicts_seen = 0;
	int        hold_left = 0;
	bit        hold_done = 1'b0;
	int        failures = 0;
	bit        want;

	always #1 clk = ~clk;

	segment_intersection_test_top #(.COORD_BITS(COORD_BITS)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.first_start_x(cur_pair.a_sx),
		.first_start_y(cur_pair.a_sy),
		.first_end_x(cur_pair.a_ex),
		.first_end_y(cur_pair.a_ey),
		.second_start_x(cur_pair.b_sx),
		.second_start_y(cur_pair.b_sy),
		.second_end_x(cur_pair.b_ex),
		.second_end_y(cur_pair.b_ey),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.segments_intersect(segments_intersect)
	);

	function automatic longint widen(coord_t c);
		return longint'($signed(c));
	endfunction

	// sign of the cross product for the triple a, b, c
	function automatic turn_t orientation_of(longint ax, longint ay, longint bx, longint by,
			longint cx, longint cy);
		longint xprod;
		xprod = (by - ay) * (cx - bx) - (bx - ax) * (cy - by);
		if (xprod == 0)
			return TURN_COLL;
		return (xprod > 0) ? TURN_CW : TURN_CCW;
	endfunction

	// m lies in the box spanned by a and b
	function automatic bit within_box(longint ax, longint ay, longint mx, longint my,
			longint bx, longint by);
		return mx <= ((ax > bx) ? ax : bx) && mx >= ((ax < bx) ? ax : bx) &&
			my <= ((ay > by) ? ay : by) && my >= ((ay < by) ? ay : by);
	endfunction

	function automatic bit segments_touch(seg_pair_t p);
		longint ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
		turn_t t1, t2, t3, t4;
		ax0 = widen(p.a_sx); ay0 = widen(p.a_sy);
		ax1 = widen(p.a_ex); ay1 = widen(p.a_ey);
		bx0 = widen(p.b_sx); by0 = widen(p.b_sy);
		bx1 = widen(p.b_ex); by1 = widen(p.b_ey);
		t1 = orientation_of(ax0, ay0, ax1, ay1, bx0, by0);
		t2 = orientation_of(ax0, ay0, ax1, ay1, bx1, by1);
		t3 = orientation_of(bx0, by0, bx1, by1, ax0, ay0);
		t4 = orientation_of(bx0, by0, bx1, by1, ax1, ay1);
		return (t1 != t2 && t3 != t4) ||
			(t1 == TURN_COLL && within_box(ax0, ay0, bx0, by0, ax1, ay1)) ||
			(t2 == TURN_COLL && within_box(ax0, ay0, bx1, by1, ax1, ay1)) ||
			(t3 == TURN_COLL && within_box(bx0, by0, ax0, ay0, bx1, by1)) ||
			(t4 == TURN_COLL && within_box(bx0, by0, ax1, ay1, bx1, by1));
	endfunction

	function automatic seg_pair_t make_pair(int ax0, int ay0, int ax1, int ay1,
			int bx0, int by0, int bx1, int by1);
		seg_pair_t p;
		p.drain_before = 1'b0;
		p.a_sx = coord_t'(ax0); p.a_sy = coord_t'(ay0);
		p.a_ex = coord_t'(ax1); p.a_ey = coord_t'(ay1);
		p.b_sx = coord_t'(bx0); p.b_sy = coord_t'(by0);
		p.b_ex = coord_t'(bx1); p.b_ey = coord_t'(by1);
		return p;
	endfunction

	function automatic int near_value(int span);
		return $urandom_range(2 * span) - span;
	endfunction

	function automatic int edge_value();
		case ($urandom_range(4))
			0: return -32768;
			1: return 32767;
			2: return 0;
			3: return -1;
			default: return int'($signed(coord_t'($urandom)));
		endcase
	endfunction

	function automatic seg_pair_t collinear_pair(int px, int py, int dx, int dy);
		int k0, k1, k2, k3;
		k0 = near_value(8); k1 = near_value(8);
		k2 = near_value(8); k3 = near_value(8);
		return make_pair(px + k0 * dx, py + k0 * dy, px + k1 * dx, py + k1 * dy,
			px + k2 * dx, py + k2 * dy, px + k3 * dx, py + k3 * dy);
	endfunction

	function automatic seg_pair_t random_pair();
		int px, py, dx, dy, n, t;
		int pick;
		pick = $urandom_range(99);
		if (pick < 35) begin
			return make_pair($urandom, $urandom, $urandom, $urandom,
				$urandom, $urandom, $urandom, $urandom);
		end else if (pick < 60) begin
			return make_pair(near_value(8), near_value(8), near_value(8), near_value(8),
				near_value(8), near_value(8), near_value(8), near_value(8));
		end else if (pick < 75) begin
			// four points on one line
			px = near_value(1000); py = near_value(1000);
			dx = near_value(40); dy = near_value(40);
			return collinear_pair(px, py, dx, dy);
		end else if (pick < 90) begin
			// second segment starts on the first one, often at an endpoint
			px = near_value(2000); py = near_value(2000);
			dx = near_value(60); dy = near_value(60);
			n = $urandom_range(1, 8);
			t = $urandom_range(n);
			if ($urandom_range(3) == 0)
				return make_pair(px, py, px + n * dx, py + n * dy,
					px + n * dx, py + n * dy, near_value(3000), near_value(3000));
			return make_pair(px, py, px + n * dx, py + n * dy,
				px + t * dx, py + t * dy, near_value(3000), near_value(3000));
		end
		return make_pair(edge_value(), edge_value(), edge_value(), edge_value(),
			edge_value(), edge_value(), edge_value(), edge_value());
	endfunction

	// transfer seen at the last rising edge
	always @(posedge clk) begin
		in_xfer <= item_valid && !item_stall;
		if (arst_n && item_valid && !item_stall)
			verdicts_due.push_back(segments_touch(cur_pair));
	end

	// sender
	always @(negedge clk) begin
		if (arst_n && (!item_valid || in_xfer)) begin
			if (pending_pairs.size() != 0 &&
					(!pending_pairs[0].drain_before || verdicts_due.size() == 0) &&
					!((pairs_sent < 450 || pairs_sent >= 600) && $urandom_range(99) < 10)) begin
				cur_pair <= pending_pairs.pop_front();
				item_valid <= 1'b1;
				pairs_sent <= pairs_sent + 1;
			end else begin
				item_valid <= 1'b0;
			end
		end
	end

	// receiver back-pressure, with one long hold-off to fill the pipeline
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_left > 0) begin
				result_stall <= 1'b1;
				hold_left <= hold_left - 1;
			end else if (verdicts_seen >= 120 && !hold_done) begin
				hold_done <= 1'b1;
				hold_left <= HOLD_CYCLES - 1;
				result_stall <= 1'b1;
			end else begin
				result_stall <= (verdicts_seen < 450 || verdicts_seen >= 600) &&
					$urandom_range(99) < 10;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			verdicts_seen <= verdicts_seen + 1;
			if (verdicts_due.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual segments_intersect=%0b",
					$time, segments_intersect);
				failures = failures + 1;
			end else begin
				want = verdicts_due.pop_front();
				if (segments_intersect !== want) begin
					$display("%0t: segments_intersect expected %0b actual %0b",
						$time, want, segments_intersect);
					failures = failures + 1;
				end
			end
		end
	end

	initial begin
		seg_pair_t p;
		// extremes, crossings, parallels, collinear and degenerate layouts
		pending_pairs.push_back(make_pair(-32768, -32768, -32768, -32768,
			-32768, -32768, -32768, -32768));
		pending_pairs.push_back(make_pair(32767, 32767, 32767, 32767,
			32767, 32767, 32767, 32767));
		pending_pairs.push_back(make_pair(-32768, -32768, 32767, 32767,
			-32768, 32767, 32767, -32768));
		pending_pairs.push_back(make_pair(-32768, -32768, 32767, 32767,
			-32768, -32767, 32766, 32767));
		pending_pairs.push_back(make_pair(0, 0, 10, 0, 5, 0, 20, 0));
		pending_pairs.push_back(make_pair(0, 0, 4, 0, 5, 0, 9, 0));
		pending_pairs.push_back(make_pair(0, 0, 5, 5, 5, 5, 9, 9));
		pending_pairs.push_back(make_pair(0, 0, 10, 0, 5, 0, 5, 7));
		pending_pairs.push_back(make_pair(3, 3, 3, 3, 0, 0, 6, 6));
		pending_pairs.push_back(make_pair(3, 4, 3, 4, 0, 0, 6, 6));
		pending_pairs.push_back(make_pair(1, 1, 1, 1, 2, 2, 2, 2));
		pending_pairs.push_back(make_pair(1, 1, 1, 1, 1, 1, 1, 1));
		pending_pairs.push_back(make_pair(0, 0, 5, 5, 11, 0, 6, 5));
		pending_pairs.push_back(make_pair(0, 0, 10, 10, 11, 0, 0, 11));
		pending_pairs.push_back(make_pair(-32768, 0, 32767, 0, 32767, 0, -32768, 0));
		pending_pairs.push_back(make_pair(-32768, -32768, -32768, 32767,
			32767, -32768, 32767, 32767));
		pending_pairs.push_back(make_pair(0, 0, 4, 0, 4, 0, 4, 9));
		pending_pairs.push_back(make_pair(-32768, -32768, 32767, 32767,
			32767, -32768, 32767, -32768));
		pending_pairs.push_back(make_pair(-1, -1, 1, 1, -1, 1, 1, -1));
		pending_pairs.push_back(make_pair(-32768, 32767, 32767, 32767,
			0, 32767, 0, 32767));
		pending_pairs.push_back(make_pair(-2, -2, 2, 2, 3, 3, 7, 7));
		for (int i = 0; i < RANDOM_PAIRS; i++) begin
			p = random_pair();
			p.drain_before = (i == 0 || i == 350);
			pending_pairs.push_back(p);
		end

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (pending_pairs.size() != 0 || item_valid)
			@(negedge clk);
		while (verdicts_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (failures == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin
		#200000;
		$display("Some tests failed");
		$finish;
	end

endmodule
